// ===== design/mqsb_pkg.sv =====
// Shared types, widths, codes and default sizes of the multi-queue shared buffer.
`timescale 1ns / 1ps
`default_nettype none

package mqsb_pkg;

  localparam int DEF_NUM_SLOTS  = 16;
  localparam int DEF_NUM_QUEUES = 4;

  localparam int OP_W   = 1;
  localparam int QID_W  = 2;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_ENQ = 1'b0;
  localparam logic [OP_W-1:0] OP_DEQ = 1'b1;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic commit;
  } mqsb_cmd_t;

  typedef struct packed {
    logic out_free;
  } mqsb_sts_t;

endpackage

`default_nettype wire

// ===== design/mqsb_in_if.sv =====
// Request channel interface: operation, queue number and word to store.
`timescale 1ns / 1ps
`default_nettype none

interface mqsb_in_if import mqsb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [QID_W-1:0]         queue_id;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output operation, output queue_id, output data_in,
                  input ready);
  modport sink   (input valid, input operation, input queue_id, input data_in,
                  output ready);
endinterface

`default_nettype wire

// ===== design/mqsb_out_if.sv =====
// Result channel interface: status code and dequeued word.
`timescale 1ns / 1ps
`default_nettype none

interface mqsb_out_if import mqsb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink   (input valid, input status, input data_out, output ready);
endinterface

`default_nettype wire

// ===== design/multi_queue_shared_buffer_top.sv =====
// Top level of the multi-queue shared buffer.
`timescale 1ns / 1ps
`default_nettype none

// NUM_QUEUES FIFO queues share NUM_SLOTS data slots, chained through a link store that
// also holds the free list. Each request word (enqueue or dequeue to one queue) returns
// exactly one result word with a status code: done, overflow when no slot is free or the
// queue number is out of range, underflow when the queue is empty or out of range. A
// request passes through an accept step that reads the queue's head and tail and the
// link of the first free slot, a fetch step that reads the head slot and writes a new
// slot, and a commit step that writes the last link and pointers (one link write port).
// A result waiting in the output register does not hold off the next request, but a
// second result stalls until the first is taken. No clearing pass follows reset: a fill
// mark stands in for the initial free-list links, so requests are accepted at once.
module multi_queue_shared_buffer_top import mqsb_pkg::*; #(
  parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
  parameter int NUM_QUEUES = DEF_NUM_QUEUES
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mqsb_in_if.sink    in_ch,
  mqsb_out_if.source out_ch
);

  mqsb_cmd_t cmd;
  mqsb_sts_t sts;

  mqsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mqsb_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_ch.operation),
    .in_queue_id  (in_ch.queue_id),
    .in_data_in   (in_ch.data_in),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.status),
    .out_data_out (out_ch.data_out)
  );

endmodule

`default_nettype wire

// ===== design/mqsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/mqsb_ctrl.sv =====
// Sequencing state machine: accept, fetch and commit of one request.
`timescale 1ns / 1ps
`default_nettype none

module mqsb_ctrl import mqsb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output mqsb_cmd_t       cmd,
  input  wire mqsb_sts_t  sts
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FETCH  = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.fetch  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/mqsb_dp.sv =====
// Datapath: pointer registers, head, tail, link and slot stores, result register.
`timescale 1ns / 1ps
`default_nettype none

module mqsb_dp import mqsb_pkg::*; #(
  parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
  parameter int NUM_QUEUES = DEF_NUM_QUEUES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mqsb_cmd_t                cmd,
  output mqsb_sts_t                     sts,
  input  wire logic [OP_W-1:0]          in_operation,
  input  wire logic [QID_W-1:0]         in_queue_id,
  input  wire logic signed [DATA_W-1:0] in_data_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [ST_W-1:0]               out_status,
  output logic signed [DATA_W-1:0]      out_data_out
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int PW = $clog2(NUM_SLOTS + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int XW = QW + QID_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(NUM_SLOTS);
  localparam logic [XW-1:0] QLIM     = XW'(NUM_QUEUES);

  logic [XW-1:0]            qid_ext;
  logic [QW-1:0]            qaddr;

  logic [OP_W-1:0]          op_r;
  logic [QW-1:0]            qaddr_r;
  logic                     qok_r;
  logic signed [DATA_W-1:0] din_r;
  logic [PW-1:0]            nfree_r;
  logic [PW-1:0]            free_head_r;
  logic [PW-1:0]            free_head_nxt;
  logic [PW-1:0]            fill_r;
  logic [PW-1:0]            fill_nxt;
  logic [NUM_QUEUES-1:0]    qinit_r;
  logic [NUM_QUEUES-1:0]    qinit_nxt;
  logic                     out_valid_r;
  logic [ST_W-1:0]          out_status_r;
  logic signed [DATA_W-1:0] out_data_r;

  logic [PW-1:0]            head_rd;
  logic [PW-1:0]            tail_rd;
  logic [PW-1:0]            link_rd;
  logic [DATA_W-1:0]        data_rd;
  logic [PW-1:0]            head_ptr;
  logic                     head_ok;
  logic                     is_enq;
  logic                     enq_ok;
  logic                     deq_ok;
  logic                     fresh;

  logic                     link_we;
  logic [SW-1:0]            link_waddr;
  logic [PW-1:0]            link_wdata;
  logic [SW-1:0]            link_raddr;
  logic                     head_we;
  logic [PW-1:0]            head_wdata;
  logic                     tail_we;

  assign qid_ext = {{QW{1'b0}}, in_queue_id};
  assign qaddr   = qid_ext[QW-1:0];

  // A queue whose head was never written reads as empty.
  assign head_ptr = qinit_r[qaddr_r] ? head_rd : NULL_PTR;
  assign head_ok  = (head_ptr < NULL_PTR);
  assign is_enq   = (op_r == OP_ENQ);
  assign enq_ok   = is_enq && qok_r && (free_head_r < NULL_PTR);
  assign deq_ok   = !is_enq && qok_r && head_ok;
  // Slots at or above the fill mark were never taken and still link in order.
  assign fresh    = (free_head_r >= fill_r);

  assign link_raddr = cmd.accept ? free_head_r[SW-1:0] : head_ptr[SW-1:0];

  always_comb begin
    link_we    = 1'b0;
    link_waddr = free_head_r[SW-1:0];
    link_wdata = NULL_PTR;
    if (cmd.fetch && enq_ok) begin
      link_we = 1'b1;
    end else if (cmd.commit && enq_ok && head_ok) begin
      link_we    = 1'b1;
      link_waddr = tail_rd[SW-1:0];
      link_wdata = free_head_r;
    end else if (cmd.commit && deq_ok) begin
      link_we    = 1'b1;
      link_waddr = head_ptr[SW-1:0];
      link_wdata = free_head_r;
    end
  end

  assign head_we    = cmd.commit && ((enq_ok && !head_ok) || deq_ok);
  assign head_wdata = deq_ok ? link_rd : free_head_r;
  assign tail_we    = cmd.commit && enq_ok;

  mqsb_ram #(.WIDTH(PW), .DEPTH(NUM_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd.accept || cmd.fetch),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  mqsb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (cmd.fetch && enq_ok),
    .waddr (free_head_r[SW-1:0]),
    .wdata (din_r),
    .re    (cmd.fetch),
    .raddr (head_ptr[SW-1:0]),
    .rdata (data_rd)
  );

  mqsb_ram #(.WIDTH(PW), .DEPTH(NUM_QUEUES)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (qaddr_r),
    .wdata (head_wdata),
    .re    (cmd.accept),
    .raddr (qaddr),
    .rdata (head_rd)
  );

  mqsb_ram #(.WIDTH(PW), .DEPTH(NUM_QUEUES)) u_tail_ram (
    .clk   (clk),
    .we    (tail_we),
    .waddr (qaddr_r),
    .wdata (free_head_r),
    .re    (cmd.accept),
    .raddr (qaddr),
    .rdata (tail_rd)
  );

  always_comb begin
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    qinit_nxt     = qinit_r;
    if (cmd.commit && enq_ok) begin
      free_head_nxt = nfree_r;
      if (fresh) begin
        fill_nxt = fill_r + PW'(1);
      end
    end else if (cmd.commit && deq_ok) begin
      free_head_nxt = head_ptr;
    end
    if (head_we) begin
      qinit_nxt[qaddr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      fill_r      <= '0;
      qinit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      qinit_r     <= qinit_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_operation;
      qaddr_r <= qaddr;
      qok_r   <= (qid_ext < QLIM);
      din_r   <= in_data_in;
    end
    if (cmd.fetch) begin
      nfree_r <= fresh ? (free_head_r + PW'(1)) : link_rd;
    end
    if (cmd.commit) begin
      if (is_enq) begin
        out_status_r <= enq_ok ? ST_DONE : ST_OVERFLOW;
        out_data_r   <= '0;
      end else begin
        out_status_r <= deq_ok ? ST_DONE : ST_UNDERFLOW;
        out_data_r   <= deq_ok ? data_rd : '0;
      end
    end
  end

  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data_out  = out_data_r;

  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= NULL_PTR)
    else $error("free list head beyond null pointer");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NULL_PTR)
    else $error("fill mark beyond slot count");

  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed request left no result word");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && enq_ok && fresh) |=> (fill_r == $past(fill_r) + PW'(1)))
    else $error("fill mark did not advance on a fresh slot");

endmodule

`default_nettype wire

// ===== tb/tb_multi_queue_shared_buffer_top.sv =====
// Self-checking testbench of the multi-queue shared buffer with a predictor and random traffic.
`timescale 1ns / 1ps

module tb_multi_queue_shared_buffer_top;
  import mqsb_pkg::*;

  localparam int NUM_SLOTS   = DEF_NUM_SLOTS;
  localparam int NUM_QUEUES  = DEF_NUM_QUEUES;
  localparam int PTR_W       = $clog2(NUM_SLOTS + 1);
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(NUM_SLOTS);
  localparam int RAND_ITEMS  = 1180;
  localparam int CALM_ITEMS  = 150;
  localparam int HOLD_START  = 100;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_LIMIT  = 2000;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [QID_W-1:0]         qid;
    logic signed [DATA_W-1:0] data;
  } req_word_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data;
  } rsp_word_t;

  logic clk;
  logic rst_n;

  mqsb_in_if  req_if ();
  mqsb_out_if rsp_if ();

  multi_queue_shared_buffer_top #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_QUEUES(NUM_QUEUES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_if),
    .out_ch(rsp_if)
  );

  logic [DATA_W-1:0] slot_word [NUM_SLOTS];
  logic [PTR_W-1:0]  slot_next [NUM_SLOTS];
  logic [PTR_W-1:0]  q_head [NUM_QUEUES];
  logic [PTR_W-1:0]  q_tail [NUM_QUEUES];
  logic [PTR_W-1:0]  free_ptr;

  req_word_t pending_reqs[$];
  rsp_word_t expected_rsps[$];
  int        total_items;
  int        req_sent;
  int        req_taken;
  int        errors;
  int        idle_cycles;
  int        src_gap;
  int        sink_gap;
  int        hold_cnt;
  bit        held;
  int        n_enq;
  int        n_deq;
  int        n_over;
  int        n_under;
  bit        busy;
  req_word_t drv_word;
  req_word_t seen_req;
  rsp_word_t want_rsp;
  rsp_word_t pred_rsp;

  function automatic rsp_word_t buffer_apply(req_word_t r);
    rsp_word_t        res;
    logic [PTR_W-1:0] slot;
    res.status = ST_DONE;
    res.data   = '0;
    if (r.op == OP_ENQ) begin
      if (int'(r.qid) >= NUM_QUEUES || free_ptr >= NUM_SLOTS) begin
        res.status = ST_OVERFLOW;
      end else begin
        slot     = free_ptr;
        free_ptr = slot_next[slot];
        if (q_head[r.qid] >= NUM_SLOTS || q_tail[r.qid] >= NUM_SLOTS) begin
          q_head[r.qid] = slot;
        end else begin
          slot_next[q_tail[r.qid]] = slot;
        end
        slot_next[slot] = NIL_PTR;
        q_tail[r.qid]   = slot;
        slot_word[slot] = r.data;
      end
    end else begin
      if (int'(r.qid) >= NUM_QUEUES || q_head[r.qid] >= NUM_SLOTS) begin
        res.status = ST_UNDERFLOW;
      end else begin
        slot            = q_head[r.qid];
        q_head[r.qid]   = slot_next[slot];
        slot_next[slot] = free_ptr;
        free_ptr        = slot;
        res.data        = slot_word[slot];
      end
    end
    return res;
  endfunction

  task automatic add_req(logic [OP_W-1:0] op, logic [QID_W-1:0] qid, logic [DATA_W-1:0] data);
    req_word_t w;
    w.op   = op;
    w.qid  = qid;
    w.data = data;
    pending_reqs.push_back(w);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_ENQ;
    req_if.queue_id   = '0;
    req_if.data_in    = '0;
    rsp_if.ready      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  initial begin
    int n;
    int mode;
    int run;
    int focus;
    int narrow;
    int enq_pct;
    logic [OP_W-1:0]   op;
    logic [QID_W-1:0]  qid;
    logic [DATA_W-1:0] data;

    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_word[i] = '0;
      slot_next[i] = (i == NUM_SLOTS - 1) ? NIL_PTR : PTR_W'(i + 1);
    end
    for (int i = 0; i < NUM_QUEUES; i++) begin
      q_head[i] = NIL_PTR;
      q_tail[i] = NIL_PTR;
    end
    free_ptr    = '0;
    req_sent    = 0;
    req_taken   = 0;
    errors      = 0;
    idle_cycles = 0;
    src_gap     = 0;
    sink_gap    = 0;
    hold_cnt    = 0;
    held        = 1'b0;
    n_enq       = 0;
    n_deq       = 0;
    n_over      = 0;
    n_under     = 0;

    // Empty queue, extreme words, then a dequeue that leaves a stale tail behind.
    add_req(OP_DEQ, 2'd0, 32'h0);
    add_req(OP_ENQ, 2'd0, 32'h7fff_ffff);
    add_req(OP_ENQ, 2'd0, 32'h8000_0000);
    add_req(OP_DEQ, 2'd0, 32'hffff_ffff);
    add_req(OP_DEQ, 2'd0, 32'h0);
    add_req(OP_DEQ, 2'd0, 32'h0);
    add_req(OP_ENQ, 2'd0, 32'h0);
    add_req(OP_ENQ, 2'd1, 32'hffff_ffff);
    add_req(OP_ENQ, 2'd2, 32'haaaa_aaaa);
    add_req(OP_ENQ, 2'd3, 32'h5555_5555);
    // Fill the whole store, then overflow it.
    for (int i = 0; i < NUM_SLOTS - 4; i++) begin
      add_req(OP_ENQ, QID_W'(i % NUM_QUEUES), $urandom);
    end
    add_req(OP_ENQ, 2'd2, $urandom);
    add_req(OP_DEQ, 2'd3, 32'h0);
    add_req(OP_DEQ, 2'd1, 32'h0);
    add_req(OP_ENQ, 2'd3, $urandom);

    n = 0;
    while (n < RAND_ITEMS) begin
      mode    = $urandom_range(0, 2);
      run     = $urandom_range(10, 60);
      focus   = $urandom_range(0, NUM_QUEUES - 1);
      narrow  = $urandom_range(0, 1);
      enq_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      repeat (run) begin
        op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        qid = (narrow != 0 && $urandom_range(0, 3) != 0) ? QID_W'(focus) : QID_W'($urandom);
        case ($urandom_range(0, 7))
          0: data = 32'h8000_0000;
          1: data = 32'h7fff_ffff;
          2: data = 32'h0;
          3: data = 32'hffff_ffff;
          default: data = $urandom;
        endcase
        add_req(op, qid, data);
        n++;
      end
    end
    total_items = pending_reqs.size();

    @(posedge rst_n);
    while (req_taken < total_items || expected_rsps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d requests: %0d enqueues and %0d dequeues done.", req_taken, n_enq, n_deq);
    $display("Full-store overflows: %0d, empty-queue underflows: %0d.", n_over, n_under);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && req_taken != req_sent) begin
      req_if.valid <= 1'b1;
    end else if (src_gap > 0) begin
      src_gap      <= src_gap - 1;
      req_if.valid <= 1'b0;
    end else if (req_sent + CALM_ITEMS < total_items && $urandom_range(0, 9) == 0) begin
      src_gap      <= $urandom_range(0, 13);
      req_if.valid <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      drv_word          = pending_reqs.pop_front();
      req_if.operation <= drv_word.op;
      req_if.queue_id  <= drv_word.qid;
      req_if.data_in   <= drv_word.data;
      req_if.valid     <= 1'b1;
      req_sent         <= req_sent + 1;
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      rsp_if.ready <= 1'b0;
    end else if (!held && req_taken >= HOLD_START) begin
      held         <= 1'b1;
      hold_cnt     <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap     <= sink_gap - 1;
      rsp_if.ready <= 1'b0;
    end else if (req_sent + CALM_ITEMS < total_items && $urandom_range(0, 7) == 0) begin
      sink_gap     <= $urandom_range(0, 13);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      busy = 1'b0;
      if (rsp_if.valid && rsp_if.ready) begin
        busy = 1'b1;
        if (expected_rsps.size() == 0) begin
          $error("Result word with no request waiting: status %0d data %0h",
                 rsp_if.status, rsp_if.data_out);
          errors++;
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (rsp_if.status !== want_rsp.status) begin
            $error("status: expected %0d, actual %0d", want_rsp.status, rsp_if.status);
            errors++;
          end
          if (rsp_if.data_out !== want_rsp.data) begin
            $error("data_out: expected %0h, actual %0h", want_rsp.data, rsp_if.data_out);
            errors++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        busy         = 1'b1;
        seen_req.op   = req_if.operation;
        seen_req.qid  = req_if.queue_id;
        seen_req.data = req_if.data_in;
        pred_rsp = buffer_apply(seen_req);
        expected_rsps.push_back(pred_rsp);
        req_taken <= req_taken + 1;
        if (pred_rsp.status == ST_OVERFLOW) n_over++;
        else if (pred_rsp.status == ST_UNDERFLOW) n_under++;
        else if (seen_req.op == OP_ENQ) n_enq++;
        else n_deq++;
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
